// ===== rtl/lpm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 longest-prefix-match block.
// No dependencies; imported by lpm_cell and ipv4_longest_prefix_match.
package lpm_pkg;

    localparam int LPM_DEPTH   = 16;
    localparam int ADDR_W      = 32;
    localparam int SLOT_W      = 4;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic
    {
        REQ_WRITE  = 1'b0,
        REQ_LOOKUP = 1'b1
    } req_type_t;

    // One item as it moves down the row of cells, with the best match so far.
    typedef struct packed
    {
        req_type_t req_type;
        slot_t     entry_index;
        addr_t     entry_dest;
        addr_t     entry_mask;
        logic      entry_valid;
        addr_t     lookup_addr;
        logic      hit;
        slot_t     best_idx;
        addr_t     best_mask;
    } lpm_item_t;

endpackage

// ===== rtl/lpm_cell.sv =====
`timescale 1ns / 1ps
// One route-table cell: holds a single entry and updates the passing item.
// Depends on lpm_pkg.
module lpm_cell #(
    parameter int CellIdx = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              vld_in,
    input  lpm_pkg::lpm_item_t item_in,
    output logic              vld_out,
    output lpm_pkg::lpm_item_t item_out
);
    import lpm_pkg::*;

    addr_t     dest_reg;
    addr_t     mask_reg;
    logic      valid_reg;
    logic      vld_reg;
    lpm_item_t item_reg;
    lpm_item_t item_next;
    logic      wr_hit;
    logic      addr_match;
    logic      better;

    assign wr_hit = vld_in && (item_in.req_type == REQ_WRITE)
                    && (int'(item_in.entry_index) == CellIdx);

    assign addr_match = ((item_in.lookup_addr ^ dest_reg) & mask_reg) == '0;
    // Strict greater keeps the lower slot on equal masks.
    assign better = !item_in.hit || (mask_reg > item_in.best_mask);

    always_comb
    begin
        item_next = item_in;
        if ((item_in.req_type == REQ_LOOKUP) && valid_reg && addr_match && better)
        begin
            item_next.hit       = 1'b1;
            item_next.best_idx  = slot_t'(CellIdx);
            item_next.best_mask = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= vld_in;
            if (wr_hit)
            begin
                valid_reg <= item_in.entry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
            if (wr_hit)
            begin
                dest_reg <= item_in.entry_dest;
                mask_reg <= item_in.entry_mask;
            end
        end
    end

    assign vld_out  = vld_reg;
    assign item_out = item_reg;

endmodule

// ===== rtl/ipv4_longest_prefix_match.sv =====
`timescale 1ns / 1ps
// IPv4 longest-prefix-match routing table built as a row of DEPTH cells.
// Each cell registers the item in turn; the result is read from the last cell's register.
// Throughput: one item per cycle; the whole row holds while the result is stalled.
// Reset (rst_n low, asynchronous): all entries invalid, row empty.
// Depends on lpm_pkg and lpm_cell.
module ipv4_longest_prefix_match #(
    parameter int DEPTH = lpm_pkg::LPM_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                req_type,
    input  lpm_pkg::slot_t      entry_index,
    input  lpm_pkg::addr_t      entry_dest,
    input  lpm_pkg::addr_t      entry_mask,
    input  logic                entry_valid,
    input  lpm_pkg::addr_t      lookup_addr,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic                found,
    output lpm_pkg::slot_t      match_index,
    output lpm_pkg::addr_t      match_mask
);
    import lpm_pkg::*;

    logic      vld_chain  [DEPTH+1];
    lpm_item_t item_chain [DEPTH+1];
    logic      advance;

    // Hold every stage while the last one waits on the consumer.
    assign advance   = !(vld_chain[DEPTH] && rsp_stall);
    assign req_stall = !advance;

    always_comb
    begin
        item_chain[0].req_type    = req_type_t'(req_type);
        item_chain[0].entry_index = entry_index;
        item_chain[0].entry_dest  = entry_dest;
        item_chain[0].entry_mask  = entry_mask;
        item_chain[0].entry_valid = entry_valid;
        item_chain[0].lookup_addr = lookup_addr;
        item_chain[0].hit         = 1'b0;
        item_chain[0].best_idx    = '0;
        item_chain[0].best_mask   = '0;
    end
    assign vld_chain[0] = req_valid;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        lpm_cell #(
            .CellIdx (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .vld_in   (vld_chain[g]),
            .item_in  (item_chain[g]),
            .vld_out  (vld_chain[g+1]),
            .item_out (item_chain[g+1])
        );
    end

    assign rsp_valid   = vld_chain[DEPTH];
    assign found       = item_chain[DEPTH].hit;
    assign match_index = item_chain[DEPTH].best_idx;
    assign match_mask  = item_chain[DEPTH].best_mask;

`ifndef SYNTHESIS
    a_write_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (item_chain[DEPTH].req_type == REQ_WRITE) |-> !found)
        else $error("write item reported a match");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> (match_index == '0) && (match_mask == '0))
        else $error("miss result carries nonzero index or mask");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("input accepted while result stalled");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> (int'(match_index) < DEPTH))
        else $error("match index beyond table depth");
`endif

endmodule
